FILE: design/ddo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_pkg: shared types and constants for the differential drive odometry core
// Item layouts, serial unit widths, fixed-point scale factors, arctan table.
// ----------------------------------------------------------------------------
package ddo_pkg;

  // one odometry tick
  typedef struct packed {
    logic signed [19:0] left_rpm;
    logic signed [19:0] right_rpm;
    logic        [19:0] elapsed_us;
  } in_item_t;

  // one odometry result
  typedef struct packed {
    logic signed [31:0] linear_speed;
    logic signed [31:0] turn_rate;
    logic signed [39:0] pos_x;
    logic signed [39:0] pos_y;
    logic        [31:0] heading;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } out_item_t;

  // serial unit widths
  localparam int MUL_AW = 56;              // multiplicand
  localparam int MUL_BW = 32;              // multiplier, one bit per cycle
  localparam int MUL_PW = MUL_AW + MUL_BW; // product
  localparam int DIV_NW = 64;              // dividend / quotient
  localparam int DIV_DW = 36;              // divisor
  localparam int TRIG_W = 34;              // CORDIC datapath, Q2.30 plus guard

  // configuration register indexes
  localparam int  CFG_IDX_W          = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_DIAMETER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_BASE     = 1'b1;
  localparam int  CFG_DATA_W         = 22;

  localparam logic [19:0] DIAM_RESET = 20'd100000;
  localparam logic [21:0] BASE_RESET = 22'd300000;

  // fixed-point scale factors
  localparam logic [21:0] PI_Q20   = 22'd3294199;
  localparam logic [29:0] ANG_K    = 30'd751587969;
  localparam logic [30:0] US_K     = 31'd1125899907;
  localparam logic [19:0] MILLION  = 20'd1000000;
  localparam logic [DIV_DW-1:0] VM_DIV = 36'd8053063680;
  localparam logic [DIV_NW-1:0] VM_RND = 64'd4026531840;
  localparam logic [DIV_DW-1:0] DQ_DIV = 36'd3932160;
  localparam logic [DIV_NW-1:0] DQ_RND = 64'd1966080;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // arctan(2^-i) as a 32-bit binary angle
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

endpackage

FILE: design/ddo_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_stream_if: valid/ready stream channel
// A transfer happens on a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface ddo_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/diff_drive_odometry_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_odometry_core: dead-reckoning odometry for a differential base
// Wheel rpm to speed and turn rate, heading integration, CORDIC trig and
// saturating position update, all on shared bit-serial units.
// ----------------------------------------------------------------------------
//  channel | dir | payload                              | transfer
//  --------+-----+--------------------------------------+----------------------
//  in_i    | in  | left_rpm, right_rpm, elapsed_us      | valid && ready
//  out_o   | out | speed, turn, x, y, heading, quat z/w | valid && ready
//  cfg     | in  | cfg_idx_i, cfg_data_i                | cfg_we_i
//
// One tick runs twelve multiplies, three divides and two CORDIC runs, back
// to back on one multiplier, one divider and one CORDIC unit, between the
// accept step and the output register.
// Reset clears heading and position and loads the default wheel geometry.
// A new tick is taken as soon as the previous one reaches the output
// register; a stalled result only holds the sequencer in its final step.
// ----------------------------------------------------------------------------
module diff_drive_odometry_core import ddo_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ddo_stream_if.sink            in_i,
  ddo_stream_if.source          out_o
);

  // sequencer steps
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_VM1  = 5'd1;
  localparam logic [4:0] ST_VM2  = 5'd2;
  localparam logic [4:0] ST_VMD  = 5'd3;
  localparam logic [4:0] ST_DQ1  = 5'd4;
  localparam logic [4:0] ST_DQ2  = 5'd5;
  localparam logic [4:0] ST_DQD  = 5'd6;
  localparam logic [4:0] ST_WM1  = 5'd7;
  localparam logic [4:0] ST_WMD  = 5'd8;
  localparam logic [4:0] ST_HD1  = 5'd9;
  localparam logic [4:0] ST_HD2  = 5'd10;
  localparam logic [4:0] ST_COR1 = 5'd11;
  localparam logic [4:0] ST_VDT  = 5'd12;
  localparam logic [4:0] ST_PX1  = 5'd13;
  localparam logic [4:0] ST_PX2  = 5'd14;
  localparam logic [4:0] ST_PY1  = 5'd15;
  localparam logic [4:0] ST_PY2  = 5'd16;
  localparam logic [4:0] ST_COR2 = 5'd17;
  localparam logic [4:0] ST_OUT  = 5'd18;

  // control and architectural state
  logic [4:0]  st_q, st_d;
  logic        launched_q, launched_d;
  logic        out_valid_q, out_valid_d;
  logic [19:0] diam_q;
  logic [21:0] base_q;
  logic [32:0] heading_q, heading_d;
  logic signed [39:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;

  // working registers
  logic [20:0] sum_mag_q, diff_mag_q;
  logic        sum_neg_q, diff_neg_q;
  logic [19:0] dt_q;
  logic [63:0] acc_q, acc_d;
  logic [29:0] vm_q, vm_d;
  logic [31:0] wm_q, wm_d;
  logic [49:0] vdt_q, vdt_d;
  logic signed [TRIG_W-1:0] c_q, c_d, s_q, s_d;
  logic signed [15:0] qz_q, qz_d, qw_q, qw_d;
  out_item_t out_q, out_d;

  // unit hookups
  logic              mul_start, mul_done;
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [MUL_PW-1:0] mul_prod;
  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_num, div_quo;
  logic [DIV_DW-1:0] div_den;
  logic              cor_start, cor_done;
  logic [31:0]       cor_ang;
  logic signed [TRIG_W-1:0] cor_cos, cor_sin;

  logic [21:0] base_nz;
  logic signed [20:0] in_sum, in_diff;

  ddo_mul_serial u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  ddo_div_serial u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  ddo_cordic_serial #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .angle_i (cor_ang),
    .done_o  (cor_done),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin)
  );

  // Q2.30 to Q1.15 with rounding and clamp
  function automatic logic signed [15:0] to_q15(input logic signed [TRIG_W-1:0] v);
    logic signed [TRIG_W-1:0] r;
    logic signed [TRIG_W-16:0] sh;
    r  = v + TRIG_W'(16384);
    sh = r[TRIG_W-1:15];
    if (sh > (TRIG_W-15)'(32767)) begin
      return 16'sd32767;
    end else if (sh < -(TRIG_W-15)'(32768)) begin
      return -16'sd32768;
    end
    return sh[15:0];
  endfunction

  // position plus a rounded step, saturated to 40 bits
  function automatic logic signed [39:0] pos_add(input logic signed [39:0] p,
                                                 input logic [MUL_PW-1:0] prod,
                                                 input logic neg);
    logic [35:0] rs;
    logic signed [40:0] step, sum;
    rs   = {1'b0, prod[83:49]} + 36'd1;
    step = 41'($signed({6'b0, rs[35:1]}));
    if (neg) begin
      step = -step;
    end
    sum = {p[39], p} + step;
    if (sum[40] != sum[39]) begin
      return sum[40] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
    end
    return sum[39:0];
  endfunction

  assign base_nz = (base_q == '0) ? 22'd1 : base_q;
  assign in_sum  = 21'(in_i.data.left_rpm) + 21'(in_i.data.right_rpm);
  assign in_diff = 21'(in_i.data.right_rpm) - 21'(in_i.data.left_rpm);

  // sequencer: launch a unit, wait for it, capture, move on
  always_comb begin
    logic [34:0] dlt;
    logic [53:0] tr;
    logic [63:0] lim;
    logic signed [TRIG_W-1:0] tmag;

    st_d        = st_q;
    launched_d  = launched_q;
    out_valid_d = out_valid_q && !out_o.ready;
    heading_d   = heading_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    acc_d       = acc_q;
    vm_d        = vm_q;
    wm_d        = wm_q;
    vdt_d       = vdt_q;
    c_d         = c_q;
    s_d         = s_q;
    qz_d        = qz_q;
    qw_d        = qw_q;
    out_d       = out_q;
    mul_start   = 1'b0;
    div_start   = 1'b0;
    cor_start   = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    div_num     = acc_q;
    div_den     = '0;
    cor_ang     = heading_q[31:0];
    in_i.ready  = 1'b0;
    dlt         = '0;
    tr          = '0;
    lim         = diff_neg_q ? 64'h80000000 : 64'h7FFFFFFF;
    tmag        = '0;

    unique case (st_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          st_d = ST_VM1;
        end
      end
      // speed sum: |L+R| * D * pi
      ST_VM1: begin
        mul_a = MUL_AW'(sum_mag_q);
        mul_b = MUL_BW'(diam_q);
        if (!launched_q) begin
          mul_start = 1'b1; launched_d = 1'b1;
        end else if (mul_done) begin
          acc_d = mul_prod[63:0]; launched_d = 1'b0; st_d = ST_VM2;
        end
      end
      ST_VM2: begin
        mul_a = MUL_AW'(acc_q[40:0]);
        mul_b = MUL_BW'(PI_Q20);
        if (!launched_q) begin
          mul_start = 1'b1; launched_d = 1'b1;
        end else if (mul_done) begin
          acc_d = mul_prod[63:0] + VM_RND; launched_d = 1'b0; st_d = ST_VMD;
        end
      end
      ST_VMD: begin
        div_den = VM_DIV;
        if (!launched_q) begin
          div_start = 1'b1; launched_d = 1'b1;
        end else if (div_done) begin
          vm_d = div_quo[29:0]; launched_d = 1'b0; st_d = ST_DQ1;
        end
      end
      // speed difference in um/s with 10 fraction bits
      ST_DQ1: begin
        mul_a = MUL_AW'(diff_mag_q);
        mul_b = MUL_BW'(diam_q);
        if (!launched_q) begin
          mul_start = 1'b1; launched_d = 1'b1;
        end else if (mul_done) begin
          acc_d = mul_prod[63:0]; launched_d = 1'b0; st_d = ST_DQ2;
        end
      end
      ST_DQ2: begin
        mul_a = MUL_AW'(acc_q[40:0]);
        mul_b = MUL_BW'(PI_Q20);
        if (!launched_q) begin
          mul_start = 1'b1; launched_d = 1'b1;
        end else if (mul_done) begin
          acc_d = mul_prod[63:0] + DQ_RND; launched_d = 1'b0; st_d = ST_DQD;
        end
      end
      ST_DQD: begin
        div_den = DQ_DIV;
        if (!launched_q) begin
          div_start = 1'b1; launched_d = 1'b1;
        end else if (div_done) begin
          acc_d = div_quo; launched_d = 1'b0; st_d = ST_WM1;
        end
      end
      // turn rate: dq * 1e6 / (B * 2^10), rounded
      ST_WM1: begin
        mul_a = MUL_AW'(acc_q[39:0]);
        mul_b = MUL_BW'(MILLION);
        if (!launched_q) begin
          mul_start = 1'b1; launched_d = 1'b1;
        end else if (mul_done) begin
          acc_d = mul_prod[63:0] + 64'({base_nz, 9'b0});
          launched_d = 1'b0; st_d = ST_WMD;
        end
      end
      ST_WMD: begin
        div_den = DIV_DW'({base_nz, 10'b0});
        if (!launched_q) begin
          div_start = 1'b1; launched_d = 1'b1;
        end else if (div_done) begin
          wm_d = (div_quo > lim) ? lim[31:0] : div_quo[31:0];
          launched_d = 1'b0; st_d = ST_HD1;
        end
      end
      // heading step: |w| * dt * K / 2^40
      ST_HD1: begin
        mul_a = MUL_AW'(wm_q);
        mul_b = MUL_BW'(dt_q);
        if (!launched_q) begin
          mul_start = 1'b1; launched_d = 1'b1;
        end else if (mul_done) begin
          acc_d = mul_prod[63:0]; launched_d = 1'b0; st_d = ST_HD2;
        end
      end
      ST_HD2: begin
        mul_a = acc_q[MUL_AW-1:0];
        mul_b = MUL_BW'(ANG_K);
        if (!launched_q) begin
          mul_start = 1'b1; launched_d = 1'b1;
        end else if (mul_done) begin
          dlt = {1'b0, mul_prod[72:39]} + 35'd1;
          heading_d = diff_neg_q ? heading_q - dlt[33:1] : heading_q + dlt[33:1];
          launched_d = 1'b0; st_d = ST_COR1;
        end
      end
      ST_COR1: begin
        cor_ang = heading_q[31:0];
        if (!launched_q) begin
          cor_start = 1'b1; launched_d = 1'b1;
        end else if (cor_done) begin
          c_d = cor_cos; s_d = cor_sin; launched_d = 1'b0; st_d = ST_VDT;
        end
      end
      ST_VDT: begin
        mul_a = MUL_AW'(vm_q);
        mul_b = MUL_BW'(dt_q);
        if (!launched_q) begin
          mul_start = 1'b1; launched_d = 1'b1;
        end else if (mul_done) begin
          vdt_d = mul_prod[49:0]; launched_d = 1'b0; st_d = ST_PX1;
        end
      end
      // x step
      ST_PX1: begin
        tmag  = c_q[TRIG_W-1] ? -c_q : c_q;
        mul_a = MUL_AW'(vdt_q);
        mul_b = tmag[31:0];
        if (!launched_q) begin
          mul_start = 1'b1; launched_d = 1'b1;
        end else if (mul_done) begin
          tr = {1'b0, mul_prod[81:29]} + 54'd1;
          acc_d = 64'(tr[53:1]); launched_d = 1'b0; st_d = ST_PX2;
        end
      end
      ST_PX2: begin
        mul_a = acc_q[MUL_AW-1:0];
        mul_b = MUL_BW'(US_K);
        if (!launched_q) begin
          mul_start = 1'b1; launched_d = 1'b1;
        end else if (mul_done) begin
          pos_x_d = pos_add(pos_x_q, mul_prod, sum_neg_q ^ c_q[TRIG_W-1]);
          launched_d = 1'b0; st_d = ST_PY1;
        end
      end
      // y step
      ST_PY1: begin
        tmag  = s_q[TRIG_W-1] ? -s_q : s_q;
        mul_a = MUL_AW'(vdt_q);
        mul_b = tmag[31:0];
        if (!launched_q) begin
          mul_start = 1'b1; launched_d = 1'b1;
        end else if (mul_done) begin
          tr = {1'b0, mul_prod[81:29]} + 54'd1;
          acc_d = 64'(tr[53:1]); launched_d = 1'b0; st_d = ST_PY2;
        end
      end
      ST_PY2: begin
        mul_a = acc_q[MUL_AW-1:0];
        mul_b = MUL_BW'(US_K);
        if (!launched_q) begin
          mul_start = 1'b1; launched_d = 1'b1;
        end else if (mul_done) begin
          pos_y_d = pos_add(pos_y_q, mul_prod, sum_neg_q ^ s_q[TRIG_W-1]);
          launched_d = 1'b0; st_d = ST_COR2;
        end
      end
      // quaternion from half the heading
      ST_COR2: begin
        cor_ang = heading_q[32:1];
        if (!launched_q) begin
          cor_start = 1'b1; launched_d = 1'b1;
        end else if (cor_done) begin
          qz_d = to_q15(cor_sin); qw_d = to_q15(cor_cos);
          launched_d = 1'b0; st_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_d.linear_speed = sum_neg_q ? -32'(vm_q) : 32'(vm_q);
          out_d.turn_rate    = diff_neg_q ? -wm_q : wm_q;
          out_d.pos_x        = pos_x_q;
          out_d.pos_y        = pos_y_q;
          out_d.heading      = heading_q[31:0];
          out_d.quat_z       = qz_q;
          out_d.quat_w       = qw_q;
          out_valid_d        = 1'b1;
          st_d               = ST_IDLE;
        end
      end
      default: begin
        st_d       = ST_IDLE;
        launched_d = 1'b0;
      end
    endcase
  end

  // control, configuration and odometry state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      launched_q  <= 1'b0;
      out_valid_q <= 1'b0;
      diam_q      <= DIAM_RESET;
      base_q      <= BASE_RESET;
      heading_q   <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
    end else begin
      st_q        <= st_d;
      launched_q  <= launched_d;
      out_valid_q <= out_valid_d;
      heading_q   <= heading_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_WHEEL_DIAMETER: diam_q <= cfg_data_i[19:0];
          CFG_WHEEL_BASE:     base_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && in_i.valid) begin
      sum_neg_q  <= in_sum[20];
      sum_mag_q  <= in_sum[20] ? 21'(-in_sum) : 21'(in_sum);
      diff_neg_q <= in_diff[20];
      diff_mag_q <= in_diff[20] ? 21'(-in_diff) : 21'(in_diff);
      dt_q       <= in_i.data.elapsed_us;
    end
    acc_q <= acc_d;
    vm_q  <= vm_d;
    wm_q  <= wm_d;
    vdt_q <= vdt_d;
    c_q   <= c_d;
    s_q   <= s_d;
    qz_q  <= qz_d;
    qw_q  <= qw_d;
    out_q <= out_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

FILE: design/ddo_mul_serial.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_mul_serial: shift-add multiplier
// Unsigned product, one multiplier bit retired per cycle.
// ----------------------------------------------------------------------------
module ddo_mul_serial import ddo_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [MUL_AW-1:0] a_i,
  input  logic [MUL_BW-1:0] b_i,
  output logic              done_o,
  output logic [MUL_PW-1:0] prod_o
);

  localparam int CW = $clog2(MUL_BW);

  logic [MUL_AW-1:0] a_q;
  logic [MUL_PW-1:0] p_q, p_d;
  logic [MUL_AW:0]   upper;
  logic [CW-1:0]     cnt_q;
  logic              busy_q, done_q;

  // add multiplicand into the top half when the low bit is set, then shift
  always_comb begin
    upper = {1'b0, p_q[MUL_PW-1:MUL_BW]} + (p_q[0] ? {1'b0, a_q} : '0);
    p_d   = {upper, p_q[MUL_BW-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(MUL_BW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      p_q <= {{MUL_AW{1'b0}}, b_i};
    end else if (busy_q) begin
      p_q <= p_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

FILE: design/ddo_div_serial.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_div_serial: restoring divider
// Unsigned quotient, one bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module ddo_div_serial import ddo_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_NW-1:0] num_i,
  input  logic [DIV_DW-1:0] den_i,
  output logic              done_o,
  output logic [DIV_NW-1:0] quo_o
);

  localparam int CW = $clog2(DIV_NW);

  logic [DIV_NW-1:0] q_q, q_d;
  logic [DIV_DW:0]   r_q, r_d, shifted;
  logic [DIV_DW-1:0] d_q;
  logic [CW-1:0]     cnt_q;
  logic              busy_q, done_q, ge;

  // bring down the next dividend bit, subtract when it fits
  always_comb begin
    shifted = {r_q[DIV_DW-1:0], q_q[DIV_NW-1]};
    ge      = shifted >= {1'b0, d_q};
    r_d     = ge ? shifted - {1'b0, d_q} : shifted;
    q_d     = {q_q[DIV_NW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DIV_NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= num_i;
      r_q <= '0;
      d_q <= den_i;
    end else if (busy_q) begin
      q_q <= q_d;
      r_q <= r_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = q_q;

endmodule

FILE: design/ddo_cordic_serial.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_cordic_serial: rotation-mode CORDIC
// Cosine and sine of a 32-bit binary angle in Q2.30, one micro-rotation a cycle.
// ----------------------------------------------------------------------------
module ddo_cordic_serial import ddo_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [31:0]              angle_i,
  output logic                     done_o,
  output logic signed [TRIG_W-1:0] cos_o,
  output logic signed [TRIG_W-1:0] sin_o
);

  localparam int CW = $clog2(CORDIC_STEPS + 1);

  logic signed [TRIG_W-1:0] x_q, y_q, z_q, x_d, y_d, z_d, dx, dy, at;
  logic [CW-1:0]  cnt_q;
  logic [4:0]     idx;
  logic           flip_q, flip;
  logic [31:0]    ang_rot;
  logic           busy_q, done_q;

  // fold the left half plane onto the right half
  always_comb begin
    flip    = (angle_i[31:30] == 2'b01) || (angle_i[31:30] == 2'b10);
    ang_rot = flip ? angle_i + 32'h80000000 : angle_i;
  end

  // one micro-rotation
  always_comb begin
    idx = 5'(cnt_q);
    dx  = x_q >>> idx;
    dy  = y_q >>> idx;
    at  = TRIG_W'(ATAN_TAB[idx]);
    if (!z_q[TRIG_W-1]) begin
      x_d = x_q - dy;
      y_d = y_q + dx;
      z_d = z_q - at;
    end else begin
      x_d = x_q + dy;
      y_d = y_q - dx;
      z_d = z_q + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= CORDIC_GAIN;
      y_q    <= '0;
      z_q    <= TRIG_W'($signed(ang_rot));
      flip_q <= flip;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign done_o = done_q;
  assign cos_o  = flip_q ? -x_q : x_q;
  assign sin_o  = flip_q ? -y_q : y_q;

endmodule

FILE: sim/diff_drive_odometry_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_odometry_core_tb: self-checking bench for the odometry core
// Drives random and corner-case ticks through the input stream, predicts
// speed, turn rate, heading, position and quaternion with a local bit-exact
// model and compares every result transfer, with random gaps on both sides.
// ----------------------------------------------------------------------------
module diff_drive_odometry_core_tb;
  import ddo_pkg::*;

  localparam int STEPS    = 16;
  localparam int LATENCY  = 700 + 2 * STEPS;
  localparam int N_RANDOM = 1130;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  ddo_stream_if #(.T(in_item_t))  tick_ch ();
  ddo_stream_if #(.T(out_item_t)) odo_ch ();

  diff_drive_odometry_core #(.CORDIC_STEPS(STEPS)) DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_i(tick_ch.sink), .out_o(odo_ch.source)
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  logic [19:0]        diam_m;
  logic [21:0]        base_m;
  logic [32:0]        head_m;
  logic signed [39:0] px_m, py_m;

  in_item_t  tick_q [$];
  out_item_t odo_exp_q [$];
  int        n_err = 0;
  int        n_odo = 0;
  bit        hold_in = 1'b0;

  // append a tick to the pending queue
  task automatic add_tick(input in_item_t t);
    tick_q.insert(tick_q.size(), t);
  endtask

  // round(a * b / 2^s), half up on magnitudes
  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [31:0] b, int s);
    logic [127:0] p;
    p = a * b + (128'd1 << (s - 1));
    return 64'(p >> s);
  endfunction

  function automatic logic signed [63:0] sra64(logic signed [63:0] v, int s);
    return v >>> s;
  endfunction

  // rotation CORDIC on a 32-bit binary angle, Q2.30 cos / sin
  task automatic trig_q30(input logic [31:0] ang, output logic signed [63:0] c,
                          output logic signed [63:0] s);
    logic [1:0] quad;
    bit flip;
    logic [31:0] a;
    logic signed [63:0] x, y, z, dx, dy;
    quad = ang[31:30];
    flip = (quad == 2'd1) || (quad == 2'd2);
    a = flip ? ang + 32'h80000000 : ang;
    z = 64'(signed'(a));
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < ((STEPS > 32) ? 32 : STEPS); i++) begin
      dx = sra64(x, i);
      dy = sra64(y, i);
      if (z >= 0) begin
        x -= dy; y += dx; z -= 64'(ATAN_TAB[i]);
      end else begin
        x += dy; y -= dx; z += 64'(ATAN_TAB[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic logic signed [15:0] q15_of(logic signed [63:0] v);
    logic signed [63:0] r;
    r = sra64(v + 16384, 15);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  function automatic logic signed [39:0] advance_pos(logic signed [39:0] p,
      logic [63:0] vmag, bit vneg, logic signed [63:0] trig, logic [19:0] dt);
    logic [63:0] t, tm;
    logic signed [63:0] d, r;
    tm = (trig < 0) ? 64'(-trig) : 64'(trig);
    t = mul_shift(vmag * dt, 32'(tm), 30);
    d = signed'(mul_shift(t, 32'd1125899907, 50));
    if (vneg != (trig < 0)) d = -d;
    r = 64'(p) + d;
    if (r > 64'sd549755813887) r = 64'sd549755813887;
    if (r < -64'sd549755813888) r = -64'sd549755813888;
    return 40'(r);
  endfunction

  // odometry update for one tick; returns the expected result
  task automatic odometry_step(input in_item_t tk, output out_item_t res);
    logic signed [63:0] sum, dif, v, w, c, s;
    logic [63:0] b, vm, dq, wm, delta, sm, dm;
    logic [127:0] prod;
    sum = 64'(tk.left_rpm) + 64'(tk.right_rpm);
    dif = 64'(tk.right_rpm) - 64'(tk.left_rpm);
    b = (base_m == 0) ? 64'd1 : 64'(base_m);
    sm = (sum < 0) ? 64'(-sum) : 64'(sum);
    dm = (dif < 0) ? 64'(-dif) : 64'(dif);
    prod = sm * diam_m * 64'd3294199 + 128'd4026531840;
    vm = 64'(prod / 128'd8053063680);
    v = (sum < 0) ? -signed'(vm) : signed'(vm);
    prod = dm * diam_m * 64'd3294199 + 128'd1966080;
    dq = 64'(prod / 128'd3932160);
    prod = dq * 128'd1000000 + (b << 9);
    wm = 64'(prod / (128'(b) << 10));
    if (dif < 0) begin
      if (wm > 64'd2147483648) wm = 64'd2147483648;
      w = -signed'(wm);
    end else begin
      if (wm > 64'd2147483647) wm = 64'd2147483647;
      w = signed'(wm);
    end
    delta = mul_shift(wm * tk.elapsed_us, 32'd751587969, 40);
    head_m = (w < 0) ? head_m - 33'(delta) : head_m + 33'(delta);
    trig_q30(head_m[31:0], c, s);
    px_m = advance_pos(px_m, vm, v < 0, c, tk.elapsed_us);
    py_m = advance_pos(py_m, vm, v < 0, s, tk.elapsed_us);
    res.linear_speed = 32'(v);
    res.turn_rate = 32'(w);
    res.pos_x = px_m;
    res.pos_y = py_m;
    res.heading = head_m[31:0];
    trig_q30(head_m[32:1], c, s);
    res.quat_z = q15_of(s);
    res.quat_w = q15_of(c);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    n_err++;
    $display("[%0t] MISMATCH %s got %0h want %0h (result %0d)", $realtime, what, got,
             want, n_odo);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // tick driver: predicts on each transfer
  int gap_in = 0;
  always @(posedge clk_i) begin
    out_item_t e;
    if (tick_ch.valid && tick_ch.ready) begin
      odometry_step(tick_ch.data, e);
      odo_exp_q.insert(odo_exp_q.size(), e);
    end
    if (!tick_ch.valid || tick_ch.ready) begin
      if (gap_in > 0 || hold_in || tick_q.size() == 0 || !rst_ni) begin
        tick_ch.valid <= 1'b0;
        if (gap_in > 0) gap_in <= gap_in - 1;
      end else begin
        tick_ch.valid <= 1'b1;
        tick_ch.data <= tick_q.pop_front();
        gap_in <= gap_len();
      end
    end
  end

  // result monitor and ready pattern
  always @(posedge clk_i) begin
    out_item_t e, g;
    if (odo_ch.valid && odo_ch.ready) begin
      g = odo_ch.data;
      if (odo_exp_q.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        e = odo_exp_q.pop_front();
        if (g.linear_speed !== e.linear_speed)
          report_mismatch("linear_speed", 64'(g.linear_speed), 64'(e.linear_speed));
        if (g.turn_rate !== e.turn_rate)
          report_mismatch("turn_rate", 64'(g.turn_rate), 64'(e.turn_rate));
        if (g.pos_x !== e.pos_x) report_mismatch("pos_x", 64'(g.pos_x), 64'(e.pos_x));
        if (g.pos_y !== e.pos_y) report_mismatch("pos_y", 64'(g.pos_y), 64'(e.pos_y));
        if (g.heading !== e.heading)
          report_mismatch("heading", 64'(g.heading), 64'(e.heading));
        if (g.quat_z !== e.quat_z) report_mismatch("quat_z", 64'(g.quat_z), 64'(e.quat_z));
        if (g.quat_w !== e.quat_w) report_mismatch("quat_w", 64'(g.quat_w), 64'(e.quat_w));
      end
      n_odo++;
    end
    odo_ch.ready <= rst_ni && (gap_len() == 0 || $urandom_range(0, 3) == 0);
  end

  initial begin
    tick_ch.valid = 1'b0;
    tick_ch.data = '0;
    odo_ch.ready = 1'b0;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [21:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_WHEEL_DIAMETER) diam_m = val[19:0];
    else base_m = val;
  endtask

  // sampled at the falling edge so that no clocked update is in progress
  task automatic drain();
    do @(negedge clk_i);
    while (tick_q.size() != 0 || tick_ch.valid || odo_exp_q.size() != 0);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  function automatic in_item_t mk_tick(int l, int r, int dt);
    in_item_t t;
    t.left_rpm = 20'(l);
    t.right_rpm = 20'(r);
    t.elapsed_us = 20'(dt);
    return t;
  endfunction

  function automatic in_item_t rand_tick();
    in_item_t t;
    int k;
    k = $urandom_range(0, 9);
    t.left_rpm = (k < 6) ? 20'(int'($urandom_range(0, 12000)) - 6000) : 20'($urandom);
    t.right_rpm = (k < 5) ? t.left_rpm + 20'(int'($urandom_range(0, 400)) - 200)
                          : 20'($urandom);
    t.elapsed_us = (k < 7) ? 20'($urandom_range(5000, 20000)) : 20'($urandom);
    return t;
  endfunction

  int phase_cfg [5][2] = '{'{100000, 300000}, '{1000000, 1}, '{1, 4000000},
                           '{524287, 0}, '{0, 4194303}};

  initial begin
    diam_m = DIAM_RESET;
    base_m = BASE_RESET;
    head_m = '0;
    px_m = '0;
    py_m = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed corners at reset geometry
    add_tick(mk_tick(0, 0, 0));
    add_tick(mk_tick(64, 64, 10000));
    add_tick(mk_tick(-524288, 524287, 1048575));
    add_tick(mk_tick(524287, -524288, 1048575));
    add_tick(mk_tick(524287, 524287, 1000000));
    add_tick(mk_tick(-524288, -524288, 1000000));
    add_tick(mk_tick(-1, 1, 1));
    add_tick(mk_tick(3000, -3000, 500000));
    for (int i = 0; i < 8; i++) add_tick(mk_tick(524287, 524287, 1048575));
    drain();

    // geometry extremes, wide base, zero base and zero diameter
    for (int p = 1; p < 5; p++) begin
      write_reg(CFG_WHEEL_DIAMETER, 22'(phase_cfg[p][0]));
      write_reg(CFG_WHEEL_BASE, 22'(phase_cfg[p][1]));
      add_tick(mk_tick(-524288, 524287, 1048575));
      add_tick(mk_tick(100, -37, 20000));
      add_tick(rand_tick());
      drain();
    end

    // random ticks over several geometries; one pause to full drain
    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_WHEEL_DIAMETER, (p == 4) ? 22'($urandom_range(1, 1000000))
                                              : 22'(phase_cfg[p][0]));
      write_reg(CFG_WHEEL_BASE, (p == 4) ? 22'($urandom_range(1, 4000000))
                                          : 22'(phase_cfg[p][1]));
      for (int i = 0; i < N_RANDOM / 5; i++) begin
        if (p == 2 && i == 50) begin
          do @(negedge clk_i);
          while (tick_q.size() != 0);
          hold_in = 1'b1;
          do @(negedge clk_i);
          while (tick_ch.valid || odo_exp_q.size() != 0);
          hold_in = 1'b0;
        end
        add_tick(rand_tick());
      end
      drain();
    end

    $display("Covered directed corners, five wheel geometries incl. zero base/diameter,");
    $display("and %0d result transfers with random gaps and stalls.", n_odo);
    if (n_err == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(64'd8 * 64'd1200 * 64'd3000);
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: files.f
design/ddo_pkg.sv
design/ddo_stream_if.sv
design/ddo_mul_serial.sv
design/ddo_div_serial.sv
design/ddo_cordic_serial.sv
design/diff_drive_odometry_core.sv
sim/diff_drive_odometry_core_tb.sv
